/* src/cfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants for the CRC-16 frame parser
// Phase codes, status codes, state and result bundles, CRC byte update.
// ----------------------------------------------------------------------------
package cfp_pkg;

   localparam int unsigned MAX_LENGTH = 256;
   localparam int unsigned LEN_LIMIT  = (MAX_LENGTH > 256) ? 256 : MAX_LENGTH;

   localparam logic [7:0]  HDR_BYTE  = 8'hAA;
   localparam int unsigned LEN_SHIFT = 6;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   localparam logic [9:0]  LEN_LIMIT_W = LEN_LIMIT[9:0];

   // parse phases
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_FLO  = 3'd1;
   localparam logic [2:0] PH_FHI  = 3'd2;
   localparam logic [2:0] PH_ID   = 3'd3;
   localparam logic [2:0] PH_PAY  = 3'd4;
   localparam logic [2:0] PH_CLO  = 3'd5;
   localparam logic [2:0] PH_CHI  = 3'd6;

   // result status codes
   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_PAYLOAD = 3'd1;
   localparam logic [2:0] ST_GOOD    = 3'd2;
   localparam logic [2:0] ST_CRC_ERR = 3'd3;
   localparam logic [2:0] ST_BAD_LEN = 3'd4;

   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] crc;
      logic [15:0] flags;
      logic [8:0]  flen;
      logic [7:0]  brecv;
      logic [7:0]  id;
      logic [7:0]  crc_lo;
   } state_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [7:0]  msg_id;
      logic [7:0]  payload_count;
      logic [15:0] frame_flags;
   } result_type;

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* src/cfp_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_step: per-byte parser step
// Next parser state and the result for one received byte.
// ----------------------------------------------------------------------------
module cfp_step (
   input  cfp_pkg::state_type  cur,
   input  logic [7:0]          rx_byte,
   output cfp_pkg::state_type  nxt,
   output cfp_pkg::result_type res
);
   import cfp_pkg::*;

   logic [15:0] crc_upd;
   logic [15:0] flags_hi;
   logic [9:0]  len_field;
   logic [8:0]  flen_m1;
   logic [8:0]  brecv_w;
   logic [8:0]  brecv_inc;
   logic [2:0]  status;
   logic [7:0]  data_b;
   logic [7:0]  idx_b;

   assign crc_upd   = crc_add(cur.crc, rx_byte);
   assign flags_hi  = {rx_byte, cur.flags[7:0]};
   assign len_field = flags_hi[15:LEN_SHIFT];
   assign flen_m1   = cur.flen - 9'd1;
   assign brecv_w   = {1'b0, cur.brecv};
   assign brecv_inc = brecv_w + 9'd1;

   always_comb begin
      nxt    = cur;
      status = ST_NONE;
      data_b = 8'd0;
      idx_b  = 8'd0;
      unique case (cur.phase)
         PH_FLO: begin
            nxt.flags = {cur.flags[15:8], rx_byte};
            nxt.crc   = crc_upd;
            nxt.phase = PH_FHI;
         end
         PH_FHI: begin
            nxt.flags = flags_hi;
            nxt.crc   = crc_upd;
            if ((len_field == 10'd0) || (len_field > LEN_LIMIT_W)) begin
               nxt.flen  = 9'd0;
               status    = ST_BAD_LEN;
               nxt.phase = PH_HUNT;
            end else begin
               nxt.flen  = len_field[8:0];
               nxt.phase = PH_ID;
            end
         end
         PH_ID: begin
            nxt.id    = rx_byte;
            nxt.crc   = crc_upd;
            nxt.brecv = 8'd0;
            nxt.phase = (cur.flen > 9'd1) ? PH_PAY : PH_CLO;
         end
         PH_PAY: begin
            if ((cur.flen != 9'd0) && (brecv_w < flen_m1)) begin
               status    = ST_PAYLOAD;
               data_b    = rx_byte;
               idx_b     = cur.brecv;
               nxt.brecv = brecv_inc[7:0];
               nxt.crc   = crc_upd;
               if (brecv_inc >= flen_m1) begin
                  nxt.phase = PH_CLO;
               end
            end else begin
               nxt.phase = PH_CLO;
            end
         end
         PH_CLO: begin
            nxt.crc_lo = rx_byte;
            nxt.phase  = PH_CHI;
         end
         PH_CHI: begin
            status    = (cur.crc == {rx_byte, cur.crc_lo}) ? ST_GOOD : ST_CRC_ERR;
            nxt.phase = PH_HUNT;
         end
         default: begin
            // hunt; the unused code behaves the same
            nxt.phase = PH_HUNT;
            if (rx_byte == HDR_BYTE) begin
               nxt.crc   = crc_add(16'h0000, rx_byte);
               nxt.phase = PH_FLO;
            end
         end
      endcase
   end

   always_comb begin
      res.status        = status;
      res.data_byte     = data_b;
      res.byte_index    = idx_b;
      res.msg_id        = nxt.id;
      res.payload_count = (nxt.flen != 9'd0) ? 8'(nxt.flen - 9'd1) : 8'd0;
      res.frame_flags   = nxt.flags;
   end

endmodule

/* src/crc16_frame_parser_top.sv */
`timescale 1ns / 1ps
// Flow: a byte is captured in the input register and stepped by the parser
// into the result register when that register is free or being drained.
// Throughput: one byte per cycle while results are taken; the input register,
// the combinational parser step and the result register move together. A result that is
// not taken holds the input register, and the input stalls behind it.
// Reset (synchronous, active high): parser returns to header hunt, CRC and
// frame fields clear, both pipeline registers empty.
// ----------------------------------------------------------------------------
// crc16_frame_parser_top: serial frame parser with CRC-16/XMODEM check
// Input register, per-byte parser step, result register; one beat per byte.
// ----------------------------------------------------------------------------
module crc16_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [7:0]  rsp_msg_id,
   output logic [7:0]  rsp_payload_count,
   output logic [15:0] rsp_frame_flags
);
   import cfp_pkg::*;

   // input register: one captured byte beat
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // parser state
   state_type  state_ff, state_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   state_type  step_state;
   result_type step_res;
   logic       advance;

   cfp_step u_step (
      .cur     (state_ff),
      .rx_byte (in_byte_ff),
      .nxt     (step_state),
      .res     (step_res)
   );

   // advance the held byte when the result slot is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      // drain the result beat
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      // step the parser and load the result register
      if (advance) begin
         state_in     = step_state;
         out_in       = step_res;
         out_valid_in = 1'b1;
         in_valid_in  = 1'b0;
      end
      // capture a new byte beat
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_byte_index    = out_ff.byte_index;
   assign rsp_msg_id        = out_ff.msg_id;
   assign rsp_payload_count = out_ff.payload_count;
   assign rsp_frame_flags   = out_ff.frame_flags;

`ifndef SYNTHESIS
   // the spare phase code is never entered
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase <= PH_CHI))
      else $error("parser entered unused phase");

   // a stepped byte always lands in the result register
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("stepped byte did not produce a result");

   // payload index stays below the frame payload count
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_PAYLOAD)) |-> (rsp_byte_index < rsp_payload_count))
      else $error("payload index out of range");

   // status codes stay within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_BAD_LEN))
      else $error("undefined status code");
`endif

endmodule

/* test/tb_crc16_frame_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_frame_parser_top: self-checking bench for the CRC-16 frame parser
// Streams directed and random byte frames through the parser under changing
// idle and stall pressure, predicts every result beat and checks each field.
// ----------------------------------------------------------------------------
module tb_crc16_frame_parser_top;
   import cfp_pkg::*;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the parser state per accepted byte, queues the
   // predicted result beat and checks beats from the result channel in order.
   // -------------------------------------------------------------------------
   class parser_scoreboard;
      logic [2:0]  phase;
      logic [15:0] crc;
      logic [15:0] flags;
      logic [8:0]  flen;
      logic [7:0]  brecv;
      logic [7:0]  id;
      logic [7:0]  crc_lo;
      result_type  expected_q[$];
      int          errors;

      function new();
         phase  = PH_HUNT;
         crc    = '0;
         flags  = '0;
         flen   = '0;
         brecv  = '0;
         id     = '0;
         crc_lo = '0;
         errors = 0;
      endfunction

      // CRC-16/XMODEM, one message bit at a time, MSB first
      static function logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
         logic [15:0] c;
         logic        fb;
         c = c_in;
         for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
         end
         return c;
      endfunction

      function void note_byte(input logic [7:0] b);
         result_type r;
         logic [9:0] len;
         r = '0;
         case (phase)
            PH_FLO: begin
               flags[7:0] = b;
               crc        = crc_step(crc, b);
               phase      = PH_FHI;
            end
            PH_FHI: begin
               flags[15:8] = b;
               crc         = crc_step(crc, b);
               len         = flags[15:LEN_SHIFT];
               if (len == 0 || len > LEN_LIMIT) begin
                  flen     = '0;
                  r.status = ST_BAD_LEN;
                  phase    = PH_HUNT;
               end else begin
                  flen  = len[8:0];
                  phase = PH_ID;
               end
            end
            PH_ID: begin
               id    = b;
               crc   = crc_step(crc, b);
               brecv = '0;
               phase = (flen > 1) ? PH_PAY : PH_CLO;
            end
            PH_PAY: begin
               if (flen > 0 && int'(brecv) < int'(flen) - 1) begin
                  r.status     = ST_PAYLOAD;
                  r.data_byte  = b;
                  r.byte_index = brecv;
                  brecv        = brecv + 8'd1;
                  crc          = crc_step(crc, b);
               end
               if (flen == 0 || int'(brecv) >= int'(flen) - 1) begin
                  phase = PH_CLO;
               end
            end
            PH_CLO: begin
               crc_lo = b;
               phase  = PH_CHI;
            end
            PH_CHI: begin
               r.status = (crc == {b, crc_lo}) ? ST_GOOD : ST_CRC_ERR;
               phase    = PH_HUNT;
            end
            default: begin
               phase = PH_HUNT;
               if (b == HDR_BYTE) begin
                  crc   = crc_step(16'h0000, b);
                  phase = PH_FLO;
               end
            end
         endcase
         r.msg_id        = id;
         r.payload_count = (flen > 0) ? 8'(flen - 9'd1) : 8'd0;
         r.frame_flags   = flags;
         expected_q.push_back(r);
      endfunction

      function void field_check(input string name, input int want, input int got);
         if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(input result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t ns: unexpected result beat, expected none, got 0x%0h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         field_check("status",        want.status,        got.status);
         field_check("data_byte",     want.data_byte,     got.data_byte);
         field_check("byte_index",    want.byte_index,    got.byte_index);
         field_check("msg_id",        want.msg_id,        got.msg_id);
         field_check("payload_count", want.payload_count, got.payload_count);
         field_check("frame_flags",   want.frame_flags,   got.frame_flags);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_byte_index;
   logic [7:0]  rsp_msg_id;
   logic [7:0]  rsp_payload_count;
   logic [15:0] rsp_frame_flags;

   parser_scoreboard sb;
   result_type       rsp_beat;
   int               send_idle_pct;
   int               rsp_stall_pct;
   int               sent_beats;

   crc16_frame_parser_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_msg_id        (rsp_msg_id),
      .rsp_payload_count (rsp_payload_count),
      .rsp_frame_flags   (rsp_frame_flags)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: the slowest legal run is far below this bound.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Receiver: drop ready at random on the falling edge, per the stall rate.
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: take a result beat at each rising edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beat.status        = rsp_status;
         rsp_beat.data_byte     = rsp_data_byte;
         rsp_beat.byte_index    = rsp_byte_index;
         rsp_beat.msg_id        = rsp_msg_id;
         rsp_beat.payload_count = rsp_payload_count;
         rsp_beat.frame_flags   = rsp_frame_flags;
         sb.check_result(rsp_beat);
      end
   end

   // Send one byte: idle at random first, then hold valid and the byte until
   // the beat is taken. Entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sb.note_byte(b);
      sent_beats++;
      @(negedge clock);
   endtask

   // Build a whole frame: header, flags, id, payload and CRC; optionally
   // flip one CRC bit, optionally fill the payload with header bytes.
   task automatic send_frame(input logic [9:0] len, input logic [7:0] id,
                             input logic [5:0] low_bits, input bit corrupt,
                             input bit hdr_fill);
      logic [7:0]  frame_q[$];
      logic [15:0] fl;
      logic [15:0] c;
      fl = {len, low_bits};
      frame_q.push_back(HDR_BYTE);
      frame_q.push_back(fl[7:0]);
      frame_q.push_back(fl[15:8]);
      frame_q.push_back(id);
      for (int i = 0; i < int'(len) - 1; i++) begin
         frame_q.push_back(hdr_fill ? HDR_BYTE : 8'($urandom));
      end
      c = 16'h0000;
      foreach (frame_q[k]) c = parser_scoreboard::crc_step(c, frame_q[k]);
      if (corrupt) c = c ^ (16'h0001 << $urandom_range(15));
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
      foreach (frame_q[k]) send_byte(frame_q[k]);
   endtask

   // Send only header and flags with the given length field.
   task automatic send_length_only(input logic [9:0] len, input logic [5:0] low_bits);
      logic [15:0] fl;
      fl = {len, low_bits};
      send_byte(HDR_BYTE);
      send_byte(fl[7:0]);
      send_byte(fl[15:8]);
   endtask

   // Hold the sender off until every predicted beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (sb.pending() != 0);
   endtask

   // Random traffic: mostly well-formed short frames, some broken ones,
   // noise and a few longer frames.
   task automatic random_traffic(input int n_beats);
      int          sel;
      int          start_beats;
      logic [9:0]  bad_len;
      start_beats = sent_beats;
      while (sent_beats - start_beats < n_beats) begin
         sel = $urandom_range(99);
         if (sel < 68) begin
            send_frame(10'($urandom_range(1, 8)), 8'($urandom), 6'($urandom), 1'b0, 1'b0);
         end else if (sel < 78) begin
            send_frame(10'($urandom_range(1, 8)), 8'($urandom), 6'($urandom), 1'b1, 1'b0);
         end else if (sel < 86) begin
            bad_len = $urandom_range(1) ? 10'd0 : 10'($urandom_range(LEN_LIMIT + 1, 1023));
            send_length_only(bad_len, 6'($urandom));
         end else if (sel < 96) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            send_frame(10'($urandom_range(9, 40)), 8'($urandom), 6'($urandom),
                       1'($urandom_range(1)), 1'b0);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int idle_by_phase[4];
      int stall_by_phase[4];
      idle_by_phase  = '{0, 45, 0, 31};
      stall_by_phase = '{0, 0, 45, 31};

      sb            = new();
      sent_beats    = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = 8'h00;
      rsp_ready     = 1'b0;

      // hold reset, then release it on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: noise while hunting, length one, header byte as payload
      // with a bad CRC, zero length, one past the limit, largest length field
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(10'd1, 8'hFF, 6'h00, 1'b0, 1'b0);
      send_frame(10'd2, 8'h00, 6'h3F, 1'b1, 1'b1);
      send_length_only(10'd0, 6'h3F);
      send_length_only(10'(LEN_LIMIT + 1), 6'h00);
      send_length_only(10'h3FF, 6'h3F);

      // sender pause until every result is back
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_by_phase[ph];
         rsp_stall_pct = stall_by_phase[ph];
         // one frame at the full length limit, in the first loaded phase
         if (ph == 1) begin
            send_frame(10'(LEN_LIMIT), 8'($urandom), 6'($urandom), 1'b0, 1'b0);
         end
         random_traffic(105);
         drain();
      end

      // settle: nothing pending, then wait on for stray beats
      rsp_stall_pct = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
